@@ rtl/core/ianp_pkg.sv @@
// ----------------------------------------------------------------------------
// ianp_pkg
// Shared constants, types and tables of the negative-angle intra angular
// predictor: register codes, controller commands and projection tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ianp_pkg;

  // Block geometry and field widths.
  localparam int MAX_BLOCK  = 32;
  localparam int PIX_W      = 8;
  localparam int BW_W       = 6;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int ROW_DEPTH  = MAX_BLOCK / 2 + 1;
  localparam int ROW_AW     = 5;
  localparam int PAIR_W     = 4;
  localparam int ROWPOS_W   = 5;
  localparam int LDPOS_W    = 6;
  localparam int IDX_W      = 7;
  localparam int PROD_W     = 11;
  localparam int FRAC_W     = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_WIDTH = 2'd0,
    CFG_ANGLE_MODE  = 2'd1,
    CFG_VERTICAL    = 2'd2
  } cfg_reg_e;

  // Command codes of an input beat.
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_ROW  = 1'b1
  } func_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic row_start;
    logic prime;
    logic run;
    logic last_pair;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [PAIR_W-1:0] pairs_m1;
  } status_t;

  // Projection of negative main indices onto the side reference, one row per mode.
  localparam logic [5:0] PROJ_TAB [8][32] = '{
    '{6'd16, 6'd32, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd6, 6'd13, 6'd19, 6'd26, 6'd32, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd4, 6'd7, 6'd11, 6'd14, 6'd18, 6'd21, 6'd25, 6'd28,
      6'd32, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd2, 6'd5, 6'd7, 6'd10, 6'd12, 6'd15, 6'd17, 6'd20,
      6'd22, 6'd25, 6'd27, 6'd30, 6'd32, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd2, 6'd4, 6'd6, 6'd8, 6'd9, 6'd11, 6'd13, 6'd15,
      6'd17, 6'd19, 6'd21, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30,
      6'd32, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd2, 6'd3, 6'd5, 6'd6, 6'd8, 6'd9, 6'd11, 6'd12,
      6'd14, 6'd15, 6'd17, 6'd18, 6'd20, 6'd21, 6'd23, 6'd24,
      6'd26, 6'd27, 6'd29, 6'd30, 6'd32, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd1, 6'd2, 6'd4, 6'd5, 6'd6, 6'd7, 6'd9, 6'd10,
      6'd11, 6'd12, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd20,
      6'd21, 6'd22, 6'd23, 6'd25, 6'd26, 6'd27, 6'd28, 6'd30,
      6'd31, 6'd32, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8,
      6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
      6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
      6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32}
  };

  // Angle step per mode; modes above eight use the steepest angle.
  function automatic logic [5:0] angle_of(input logic [MODE_W-1:0] mode);
    logic [5:0] ang;
    case (mode)
      4'd0:    ang = 6'd0;
      4'd1:    ang = 6'd2;
      4'd2:    ang = 6'd5;
      4'd3:    ang = 6'd9;
      4'd4:    ang = 6'd13;
      4'd5:    ang = 6'd17;
      4'd6:    ang = 6'd21;
      4'd7:    ang = 6'd26;
      default: ang = 6'd32;
    endcase
    return ang;
  endfunction

  // Side reference entry for a projected index.
  function automatic logic [5:0] proj_of(input logic [2:0] mode_m1, input logic [4:0] n);
    return PROJ_TAB[mode_m1][n];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ianp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ianp_ctrl
// Controller of the predictor: takes command beats, sequences one row as a
// priming read followed by one read per pixel pair.
// ----------------------------------------------------------------------------
`default_nettype none

module ianp_ctrl import ianp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic    func_i,
  input  wire status_t status_i,
  output logic         busy_o,
  output cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PRIME = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [PAIR_W-1:0] k_q, k_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (func_e'(func_i) == FUNC_ROW) begin
            cmd_o.row_start = 1'b1;
            state_d         = ST_PRIME;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_PRIME: begin
        cmd_o.prime = 1'b1;
        k_d         = '0;
        state_d     = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.run       = 1'b1;
        cmd_o.last_pair = (k_q == status_i.pairs_m1);
        if (k_q == status_i.pairs_m1) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // State and pair counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

`ifndef SYNTH
  // A priming read is always followed by the pair reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.prime |=> (state_q == ST_RUN))
    else $error("ianp_ctrl: priming read not followed by pair reads");

  // The last pair read closes the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.run && cmd_o.last_pair) |=> (state_q == ST_IDLE))
    else $error("ianp_ctrl: row did not end after last pair");

  // Within a row the pair counter steps by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> ((state_q == ST_IDLE) || (k_q == 4'($past(k_q) + 4'd1))))
    else $error("ianp_ctrl: pair counter skipped");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ianp_dp.sv @@
// ----------------------------------------------------------------------------
// ianp_dp
// Datapath of the predictor: reference stores, load and row positions,
// fetch address decode, and the two-tap interpolation of one pixel pair.
// ----------------------------------------------------------------------------
`default_nettype none

module ianp_dp import ianp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              restart_i,
  input  wire logic [BW_W-1:0]   block_width_i,
  input  wire logic [MODE_W-1:0] angle_mode_i,
  input  wire logic              vertical_i,
  input  wire logic [PIX_W-1:0]  a_even_i,
  input  wire logic [PIX_W-1:0]  a_odd_i,
  input  wire logic [PIX_W-1:0]  b_even_i,
  input  wire logic [PIX_W-1:0]  b_odd_i,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  output logic [PIX_W-1:0]       pixel_first_o,
  output logic [PIX_W-1:0]       pixel_second_o,
  output logic                   row_end_o,
  output logic                   block_end_o,
  output logic                   out_valid_o
);

  typedef struct packed {
    logic       zero;
    logic       bank_a;
    logic [5:0] entry;
  } fetch_t;

  typedef struct packed {
    logic zero;
    logic bank_a;
    logic lane;
  } sel_t;

  // Decode of one signed main index into a store, an entry, or a zero read.
  function automatic fetch_t decode(input logic [IDX_W-1:0] x, input logic [MODE_W-1:0] m,
                                    input logic vert);
    fetch_t     res;
    logic [4:0] n;
    res = '0;
    n   = ~x[4:0];
    if (x[IDX_W-1]) begin
      res.bank_a = ~vert;
      if (m == 4'd0) begin
        res.zero = 1'b1;
      end else begin
        res.entry = proj_of(3'(m - 4'd1), n);
      end
    end else begin
      res.bank_a = vert;
      if (x[5:0] > 6'd32) begin
        res.zero = 1'b1;
      end else begin
        res.entry = x[5:0];
      end
    end
    return res;
  endfunction

  // Selected pixel out of the two registered row words.
  function automatic logic [PIX_W-1:0] pick(input sel_t s, input logic [2*PIX_W-1:0] wa,
                                            input logic [2*PIX_W-1:0] wb);
    logic [2*PIX_W-1:0] w;
    w = s.bank_a ? wa : wb;
    if (s.zero) begin
      return '0;
    end
    return s.lane ? w[2*PIX_W-1:PIX_W] : w[PIX_W-1:0];
  endfunction

  // Rounded two-tap blend with weights (32 - f) and f.
  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] p0,
                                             input logic [PIX_W-1:0] p1,
                                             input logic [FRAC_W-1:0] f);
    logic [5:0]  w0;
    logic [13:0] acc;
    w0  = 6'd32 - {1'b0, f};
    acc = 14'({6'd0, p0} * {8'd0, w0}) + 14'({6'd0, p1} * {9'd0, f}) + 14'd16;
    return acc[12:5];
  endfunction

  // Positions, row geometry and the reference stores.
  logic [LDPOS_W-1:0]   load_pos_q;
  logic [ROWPOS_W-1:0]  row_pos_q;
  logic [PROD_W-1:0]    p_q;
  logic                 last_row_q;
  logic signed [IDX_W-1:0] cur_q;
  logic [2*PIX_W-1:0]   mem_a [ROW_DEPTH];
  logic [2*PIX_W-1:0]   mem_b [ROW_DEPTH];

  // Read stage and output stage.
  logic [2*PIX_W-1:0]   rd_a0_q, rd_a1_q, rd_b0_q, rd_b1_q;
  sel_t                 sel0_q, sel1_q;
  logic                 prime_q, run_q, last_pair_q, blk_q;
  logic [PIX_W-1:0]     v0_q;
  logic [PIX_W-1:0]     pix0_q, pix1_q;
  logic                 row_end_q, block_end_q, out_valid_q;

  logic [BW_W-1:0]      lim;
  logic [BW_W-1:0]      rows;
  logic [BW_W-1:0]      r1;
  logic                 last_row;
  logic [4:0]           half;
  logic [MODE_W-1:0]    eff_m;
  logic [11:0]          prod_full;
  logic [11:0]          ceil_sum;
  logic [IDX_W-1:0]     dint;
  logic [FRAC_W-1:0]    frac;
  logic [IDX_W-1:0]     x0, x1;
  fetch_t               fe0, fe1;
  logic [ROW_AW-1:0]    rd_row0, rd_row1;
  logic [ROW_AW-1:0]    ld_row;
  logic                 ld_wr;
  logic [PIX_W-1:0]     val0, val1;

  // Load limit, row count and pairs per row from the block width.
  always_comb begin
    lim  = (block_width_i <= 6'd32 && !block_width_i[0]) ? block_width_i : 6'd32;
    rows = (block_width_i >= 6'd1 && block_width_i <= 6'd32) ? block_width_i : 6'd32;
    half = block_width_i[5:1];
    if (block_width_i >= 6'd2 && block_width_i <= 6'd32 && !block_width_i[0]) begin
      status_o.pairs_m1 = 4'(half - 5'd1);
    end else begin
      status_o.pairs_m1 = 4'd15;
    end
    r1       = {1'b0, row_pos_q} + 6'd1;
    last_row = (r1 >= rows);
    eff_m    = (angle_mode_i > 4'd8) ? 4'd8 : angle_mode_i;
    prod_full = {6'd0, r1} * {6'd0, angle_of(angle_mode_i)};
  end

  // Integer offset and fraction of the current row.
  always_comb begin
    ceil_sum = {1'b0, p_q} + 12'd31;
    dint     = 7'd1 - ceil_sum[11:5];
    frac     = 5'd0 - p_q[4:0];
  end

  // Fetch addresses: the priming read takes the row offset, pair reads the cursor.
  always_comb begin
    x0      = cmd_i.prime ? dint : cur_q;
    x1      = x0 + 7'd1;
    fe0     = decode(x0, eff_m, vertical_i);
    fe1     = decode(x1, eff_m, vertical_i);
    rd_row0 = fe0.entry[5:1];
    rd_row1 = fe1.entry[5:1];
    ld_row  = load_pos_q[5:1];
    ld_wr   = cmd_i.load && (load_pos_q <= lim);
  end

  // Reference stores: one two-pixel row written per load beat, two rows read.
  // At the load limit only the even pixel is written; the odd entry keeps its value.
  always_ff @(posedge clk_i) begin
    if (ld_wr) begin
      mem_a[ld_row][PIX_W-1:0] <= a_even_i;
      mem_b[ld_row][PIX_W-1:0] <= b_even_i;
      if (load_pos_q != lim) begin
        mem_a[ld_row][2*PIX_W-1:PIX_W] <= a_odd_i;
        mem_b[ld_row][2*PIX_W-1:PIX_W] <= b_odd_i;
      end
    end
    if (cmd_i.prime || cmd_i.run) begin
      rd_a0_q <= mem_a[rd_row0];
      rd_a1_q <= mem_a[rd_row1];
      rd_b0_q <= mem_b[rd_row0];
      rd_b1_q <= mem_b[rd_row1];
    end
  end

  // Load and row positions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      row_pos_q  <= '0;
    end else if (restart_i) begin
      load_pos_q <= '0;
      row_pos_q  <= '0;
    end else if (cmd_i.row_start) begin
      if (last_row) begin
        load_pos_q <= '0;
        row_pos_q  <= '0;
      end else begin
        row_pos_q <= r1[ROWPOS_W-1:0];
      end
    end else if (ld_wr) begin
      load_pos_q <= (load_pos_q == lim) ? load_pos_q + 6'd1 : load_pos_q + 6'd2;
    end
  end

  // Row setup and fetch cursor.
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_start) begin
      p_q        <= prod_full[PROD_W-1:0];
      last_row_q <= last_row;
    end
    if (cmd_i.prime) begin
      cur_q <= $signed(dint + 7'd1);
    end else if (cmd_i.run) begin
      cur_q <= cur_q + 7'sd2;
    end
  end

  // Read stage tags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q     <= 1'b0;
      run_q       <= 1'b0;
      last_pair_q <= 1'b0;
      blk_q       <= 1'b0;
    end else begin
      prime_q     <= cmd_i.prime;
      run_q       <= cmd_i.run;
      last_pair_q <= cmd_i.run && cmd_i.last_pair;
      blk_q       <= cmd_i.run && cmd_i.last_pair && last_row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sel0_q <= '{zero: fe0.zero, bank_a: fe0.bank_a, lane: fe0.entry[0]};
    sel1_q <= '{zero: fe1.zero, bank_a: fe1.bank_a, lane: fe1.entry[0]};
  end

  assign val0 = pick(sel0_q, rd_a0_q, rd_b0_q);
  assign val1 = pick(sel1_q, rd_a1_q, rd_b1_q);

  // Interpolation stage: the carried pixel and two new ones make one pair.
  always_ff @(posedge clk_i) begin
    if (prime_q) begin
      v0_q <= val0;
    end else if (run_q) begin
      v0_q   <= val1;
      pix0_q <= blend(v0_q, val0, frac);
      pix1_q <= blend(val0, val1, frac);
    end
  end

  // Result strobe and row markers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      row_end_q   <= 1'b0;
      block_end_q <= 1'b0;
    end else begin
      out_valid_q <= run_q;
      row_end_q   <= last_pair_q;
      block_end_q <= blk_q;
    end
  end

  assign pixel_first_o  = pix0_q;
  assign pixel_second_o = pix1_q;
  assign row_end_o      = row_end_q;
  assign block_end_o    = block_end_q;
  assign out_valid_o    = out_valid_q;

`ifndef SYNTH
  // Every pair read yields one result beat through the read and output stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run |=> ##1 out_valid_q)
    else $error("ianp_dp: pair read produced no result");

  // The block end marker only comes with a row end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_end_q |-> (row_end_q && out_valid_q))
    else $error("ianp_dp: block end without row end");

  // The load position never runs past one beyond the last entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_pos_q <= 6'd33)
    else $error("ianp_dp: load position out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/core/intra_angular_negative_predictor.sv @@
// ----------------------------------------------------------------------------
// intra_angular_negative_predictor
// Negative-angle intra angular predictor: loads two reference arrays and
// produces the predicted block one row per request, one pixel pair a beat.
// ----------------------------------------------------------------------------
//
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------
// command   | in        | start high, busy low       | func, a/b even/odd pixels
// result    | out       | out_valid_o strobe         | pixel pair, row/block end
// config    | in        | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// A load beat leaves busy low, so the next beat may follow.
// A row request keeps busy high after its accept (one priming read, then
// one pair read a cycle), and a new command is taken once busy falls.
// Each pair is read from the two-port reference stores and leaves through
// the read stage and the output stage; a row's results stream on
// consecutive cycles and cannot be stalled. Reset clears positions and
// sets the configuration to its defaults; the stores hold no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module intra_angular_negative_predictor import ianp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  func_i,
  input  wire logic [PIX_W-1:0]      a_even_i,
  input  wire logic [PIX_W-1:0]      a_odd_i,
  input  wire logic [PIX_W-1:0]      b_even_i,
  input  wire logic [PIX_W-1:0]      b_odd_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                       out_valid_o,
  output logic [PIX_W-1:0]           pixel_first_o,
  output logic [PIX_W-1:0]           pixel_second_o,
  output logic                       row_end_o,
  output logic                       block_end_o
);

  logic [BW_W-1:0]   block_width_q;
  logic [MODE_W-1:0] angle_mode_q;
  logic              vertical_q;
  logic              restart;
  logic              busy_int;
  logic              start_ok;
  cmd_t              cmd;
  status_t           status;

  // Configuration registers; any valid write restarts the block.
  always_comb begin
    restart = 1'b0;
    case (cfg_reg_e'(cfg_idx_i))
      CFG_BLOCK_WIDTH: restart = cfg_we_i;
      CFG_ANGLE_MODE:  restart = cfg_we_i;
      CFG_VERTICAL:    restart = cfg_we_i;
      default:         restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_width_q <= 6'd4;
      angle_mode_q  <= 4'd1;
      vertical_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_BLOCK_WIDTH: block_width_q <= cfg_wdata_i;
        CFG_ANGLE_MODE:  angle_mode_q  <= cfg_wdata_i[MODE_W-1:0];
        CFG_VERTICAL:    vertical_q    <= cfg_wdata_i[0];
        default:         vertical_q    <= vertical_q;
      endcase
    end
  end

  assign start_ok = start;

  ianp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_ok),
    .func_i   (func_i),
    .status_i (status),
    .busy_o   (busy_int),
    .cmd_o    (cmd)
  );

  ianp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (restart),
    .block_width_i  (block_width_q),
    .angle_mode_i   (angle_mode_q),
    .vertical_i     (vertical_q),
    .a_even_i       (a_even_i),
    .a_odd_i        (a_odd_i),
    .b_even_i       (b_even_i),
    .b_odd_i        (b_odd_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .pixel_first_o  (pixel_first_o),
    .pixel_second_o (pixel_second_o),
    .row_end_o      (row_end_o),
    .block_end_o    (block_end_o),
    .out_valid_o    (out_valid_o)
  );

  assign busy = busy_int;

endmodule

`default_nettype wire

@@ tb/intra_angular_negative_predictor_test.sv @@
// ----------------------------------------------------------------------------
// intra_angular_negative_predictor_test
// Self-checking test of the negative-angle intra angular predictor. A model
// kept in the bench mirrors the reference stores, the registers and the load
// and row positions. It predicts every pixel pair of each row request, and a
// monitor compares each result beat, field by field, with the oldest
// prediction. Directed tests cover the register defaults, a full store fill,
// the restart rules, the odd and out-of-range widths and the block wrap. A
// random mix of whole blocks, broken blocks and noise follows, and a steady
// stream without gaps closes the run.
// ----------------------------------------------------------------------------
module intra_angular_negative_predictor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ianp_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_BEATS  = 70;
  localparam int MAX_PRINTED   = 100;
  localparam int TIMEOUT_NS    = 5_000_000;

  // Angle step of each mode, steepest last.
  localparam int unsigned ANGLE_STEP [9] = '{0, 2, 5, 9, 13, 17, 21, 26, 32};

  typedef struct packed {
    func_e            func;
    logic [PIX_W-1:0] a_even;
    logic [PIX_W-1:0] a_odd;
    logic [PIX_W-1:0] b_even;
    logic [PIX_W-1:0] b_odd;
  } request_t;

  typedef struct packed {
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] second;
    logic             row_end;
    logic             block_end;
  } pixel_pair_t;

  // Block inputs, all at known values from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic                  func_i      = 1'b0;
  logic [PIX_W-1:0]      a_even_i    = '0;
  logic [PIX_W-1:0]      a_odd_i     = '0;
  logic [PIX_W-1:0]      b_even_i    = '0;
  logic [PIX_W-1:0]      b_odd_i     = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  out_valid_o;
  logic [PIX_W-1:0]      pixel_first_o;
  logic [PIX_W-1:0]      pixel_second_o;
  logic                  row_end_o;
  logic                  block_end_o;

  // Mirror of the block: stores, registers and positions.
  logic [PIX_W-1:0] store_a [0:MAX_BLOCK];
  logic [PIX_W-1:0] store_b [0:MAX_BLOCK];
  int unsigned      blk_width = 4;
  int unsigned      mode_sel  = 1;
  int unsigned      vert_sel  = 0;
  int unsigned      load_pos  = 0;
  int unsigned      next_row  = 0;

  pixel_pair_t      pair_expect_q [$];
  int               error_count = 0;
  int unsigned      taken_beats = 0;
  bit               steady      = 1'b0;

  intra_angular_negative_predictor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .a_even_i       (a_even_i),
    .a_odd_i        (a_odd_i),
    .b_even_i       (b_even_i),
    .b_odd_i        (b_odd_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .pixel_first_o  (pixel_first_o),
    .pixel_second_o (pixel_second_o),
    .row_end_o      (row_end_o),
    .block_end_o    (block_end_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Print a mismatch and count it; printing stops after a while to keep the log short.
  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
    error_count++;
  endtask

  // Modes above eight use the steepest angle.
  function automatic int unsigned steep_mode();
    return (mode_sel > 8) ? 8 : mode_sel;
  endfunction

  // Side reference slot for projected index n, from the inverse angle.
  function automatic int unsigned side_slot(input int unsigned mode, input int unsigned n);
    int unsigned inv_angle;
    int unsigned slot;
    inv_angle = 8192 / ANGLE_STEP[mode];
    slot      = ((n + 1) * inv_angle + 128) >> 8;
    return (slot > MAX_BLOCK) ? 0 : slot;
  endfunction

  // Main reference pixel; negative indices are projected onto the side array.
  function automatic int unsigned ref_sample(input int idx);
    int unsigned mode;
    int unsigned slot;
    mode = steep_mode();
    if (idx < 0) begin
      if (mode == 0) return 0;
      slot = side_slot(mode, (-idx - 1) & 31);
      return vert_sel ? store_b[slot] : store_a[slot];
    end
    if (idx > MAX_BLOCK) return 0;
    return vert_sel ? store_a[idx] : store_b[idx];
  endfunction

  function automatic int unsigned rows_of(input int unsigned w);
    return (w >= 1 && w <= MAX_BLOCK) ? w : MAX_BLOCK;
  endfunction

  function automatic int unsigned load_limit(input int unsigned w);
    return (w <= MAX_BLOCK && w % 2 == 0) ? w : MAX_BLOCK;
  endfunction

  // A load beat stores two pixels per array, only the even one at the limit.
  task automatic predict_load(input request_t req, output bit taken);
    int unsigned limit;
    limit = load_limit(blk_width);
    taken = (load_pos <= limit);
    if (!taken) return;
    store_a[load_pos] = req.a_even;
    store_b[load_pos] = req.b_even;
    if (load_pos == limit) begin
      load_pos = load_pos + 1;
    end else begin
      store_a[load_pos + 1] = req.a_odd;
      store_b[load_pos + 1] = req.b_odd;
      load_pos = load_pos + 2;
    end
  endtask

  // Work out every pixel pair of the next row and queue them in order.
  task automatic predict_row();
    int unsigned rows;
    int unsigned pairs;
    int unsigned r;
    int unsigned shift;
    int unsigned frac;
    int          base;
    int          i0;
    bit          last_row;
    int unsigned v0, v1, v2, o0, o1;
    pixel_pair_t pp;
    rows     = rows_of(blk_width);
    pairs    = (blk_width >= 2 && blk_width <= MAX_BLOCK && blk_width % 2 == 0) ?
               blk_width / 2 : 16;
    r        = next_row & 31;
    shift    = (r + 1) * ANGLE_STEP[steep_mode()];
    base     = 1 - int'((shift + 31) >> 5);
    frac     = (32 - (shift & 31)) & 31;
    last_row = (r + 1 >= rows);
    for (int k = 0; k < pairs; k++) begin
      i0 = 2 * k + base;
      v0 = ref_sample(i0);
      v1 = ref_sample(i0 + 1);
      v2 = ref_sample(i0 + 2);
      if (frac != 0) begin
        o0 = ((32 - frac) * v0 + frac * v1 + 16) >> 5;
        o1 = ((32 - frac) * v1 + frac * v2 + 16) >> 5;
      end else begin
        o0 = v0;
        o1 = v1;
      end
      pp.first     = PIX_W'(o0);
      pp.second    = PIX_W'(o1);
      pp.row_end   = (k + 1 == pairs);
      pp.block_end = (k + 1 == pairs) && last_row;
      pair_expect_q.push_back(pp);
    end
    if (last_row) begin
      next_row = 0;
      load_pos = 0;
    end else begin
      next_row = r + 1;
    end
  endtask

  // Compare each result beat with the oldest predicted pair.
  always @(posedge clk_i) begin
    pixel_pair_t want;
    if (rst_ni && out_valid_o) begin
      if (pair_expect_q.size() == 0) begin
        report_mismatch($sformatf("pixel pair %0d/%0d with nothing expected",
                                  pixel_first_o, pixel_second_o));
      end else begin
        want = pair_expect_q.pop_front();
        if (pixel_first_o !== want.first)
          report_mismatch($sformatf("pixel_first %0d, expected %0d",
                                    pixel_first_o, want.first));
        if (pixel_second_o !== want.second)
          report_mismatch($sformatf("pixel_second %0d, expected %0d",
                                    pixel_second_o, want.second));
        if (row_end_o !== want.row_end)
          report_mismatch($sformatf("row_end %b, expected %b", row_end_o, want.row_end));
        if (block_end_o !== want.block_end)
          report_mismatch($sformatf("block_end %b, expected %b",
                                    block_end_o, want.block_end));
      end
    end
  end

  // Random pixel with the extremes weighted in.
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic request_t make_request(input func_e func);
    request_t req;
    req.func   = func;
    req.a_even = rand_pixel();
    req.a_odd  = rand_pixel();
    req.b_even = rand_pixel();
    req.b_odd  = rand_pixel();
    return req;
  endfunction

  // Drive one beat, wait for its accept, predict it, then maybe idle a burst.
  task automatic send_request(input request_t req);
    bit taken;
    start    = 1'b1;
    func_i   = req.func;
    a_even_i = req.a_even;
    a_odd_i  = req.a_odd;
    b_even_i = req.b_even;
    b_odd_i  = req.b_odd;
    do @(posedge clk_i); while (busy);
    if (req.func == FUNC_ROW) begin
      predict_row();
      taken = 1'b1;
    end else begin
      predict_load(req, taken);
    end
    if (taken) taken_beats++;
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
  endtask

  task automatic send_loads(input int unsigned count);
    repeat (count) send_request(make_request(FUNC_LOAD));
  endtask

  task automatic send_rows(input int unsigned count);
    repeat (count) send_request(make_request(FUNC_ROW));
  endtask

  // Hold off until every predicted pair has come out and the block is idle.
  task automatic settle();
    start = 1'b0;
    while (pair_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Any register write also restarts the load and row positions.
  task automatic write_register(input cfg_reg_e idx, input int unsigned value);
    start       = 1'b0;
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = CFG_DATA_W'(value);
    @(posedge clk_i);
    case (idx)
      CFG_BLOCK_WIDTH: blk_width = value & 63;
      CFG_ANGLE_MODE:  mode_sel  = value & 15;
      CFG_VERTICAL:    vert_sel  = value & 1;
      default: ;
    endcase
    load_pos = 0;
    next_row = 0;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input int unsigned w, input int unsigned mode, input int unsigned vert);
    settle();
    write_register(CFG_BLOCK_WIDTH, w);
    write_register(CFG_ANGLE_MODE, mode);
    write_register(CFG_VERTICAL, vert);
  endtask

  // Reset settings: width 4, second angle, B as main reference.
  task automatic test_reset_config();
    send_request('{FUNC_LOAD, 8'h00, 8'hFF, 8'hFF, 8'h00});
    send_request('{FUNC_LOAD, 8'hFF, 8'h00, 8'h00, 8'hFF});
    send_loads(1);
    send_rows(2);
  endtask

  // Fill all entries of both stores, then one load past the limit is ignored.
  task automatic test_store_fill();
    configure(32, 8, 1);
    send_loads(load_limit(32) / 2 + 1);
    send_loads(1);
    send_rows(1);
  endtask

  // An angle index above eight restarts the block; rows may come before loading ends.
  task automatic test_restart_rules();
    settle();
    write_register(CFG_ANGLE_MODE, 9);
    send_rows(1);
    send_loads(1);
    send_rows(1);
  endtask

  // Odd width gives sixteen pairs; zero width also reads past the main array end.
  task automatic test_odd_widths();
    configure(5, 15, 1);
    send_rows(2);
    configure(0, 0, 0);
    send_rows(1);
  endtask

  // The smallest even-width block ends after two rows and then wraps to its first row.
  task automatic test_block_wrap();
    configure(2, 4, 0);
    send_loads(2);
    send_rows(3);
  endtask

  // Whole blocks with random content, broken blocks and noise, mostly small sizes.
  task automatic test_random_mix();
    int unsigned target;
    int unsigned w;
    int unsigned mode;
    int unsigned nloads;
    int unsigned nrows;
    target = taken_beats + RANDOM_BEATS;
    while (taken_beats < target) begin
      case ($urandom_range(0, 19))
        15:      w = 32;
        16:      w = 2 * $urandom_range(0, 7) + 1;
        17:      w = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
        12, 13, 14: w = 2 * $urandom_range(7, 10);
        default: w = 2 * $urandom_range(1, 6);
      endcase
      mode = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      configure(w, mode, $urandom_range(0, 1));
      nloads = load_limit(w) / 2 + 1;
      nrows  = rows_of(w);
      case ($urandom_range(0, 3))
        0: begin
          repeat ($urandom_range(3, 12))
            send_request(make_request($urandom_range(0, 1) ? FUNC_ROW : FUNC_LOAD));
        end
        1: begin
          send_loads($urandom_range(0, nloads));
          send_rows($urandom_range(1, nrows));
        end
        default: begin
          send_loads(nloads);
          send_rows(nrows + $urandom_range(0, 2));
        end
      endcase
    end
  endtask

  // A whole block back to back, with no idle cycles on the command side.
  task automatic test_steady_stream();
    steady = 1'b1;
    configure(8, 6, 1);
    send_loads(5);
    send_rows(8);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_store_fill();
    test_restart_rules();
    test_odd_widths();
    test_block_wrap();
    test_random_mix();
    test_steady_stream();

    settle();
    if (pair_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d pixel pairs never came out", pair_expect_q.size()));
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ianp_pkg.sv
rtl/core/ianp_ctrl.sv
rtl/core/ianp_dp.sv
rtl/core/intra_angular_negative_predictor.sv
tb/intra_angular_negative_predictor_test.sv
